/* rtl/rbr_pkg.sv */
// Shared types and codes of the reorder buffer receiver.
package rbr_pkg;

   localparam int SEQ_W = 32;
   localparam int MSG_W = 32;

   localparam logic [SEQ_W-1:0] SEQ_MAX = '1;

   // result kind codes
   localparam logic KIND_STATUS  = 1'b0;
   localparam logic KIND_DELIVER = 1'b1;

   // result status codes
   localparam logic [1:0] STATUS_DUP       = 2'd0;
   localparam logic [1:0] STATUS_STORED    = 2'd1;
   localparam logic [1:0] STATUS_DELIVERED = 2'd2;
   localparam logic [1:0] STATUS_BEYOND    = 2'd3;

   typedef struct packed {
      logic [SEQ_W-1:0] seq_num;
      logic [MSG_W-1:0] message_word;
   } req_type;

   typedef struct packed {
      logic             kind;
      logic [1:0]       status;
      logic [SEQ_W-1:0] out_seq;
      logic [MSG_W-1:0] out_message;
      logic             last;
   } rsp_type;

   // operation chosen by the front end for one request
   typedef enum logic [1:0] {
      OP_DUP,
      OP_STORE,
      OP_NEXT,
      OP_BEYOND
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [SEQ_W-1:0] seq;
      logic [MSG_W-1:0] msg;
   } cmd_type;

   // what the back end tells the front end about committed state
   typedef struct packed {
      logic             idle;
      logic [SEQ_W-1:0] last_delivered;
   } back_status_type;

endpackage

/* rtl/rbr_fifo.sv */
// Small register-based first-in first-out queue.
module rbr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == DEPTH_CNT);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/rbr_front.sv */
// Front end: holds one request and classifies it against committed state.
module rbr_front #(
   parameter int WINDOW = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  rbr_pkg::req_type               req_payload,
   input  rbr_pkg::back_status_type       back_status,
   input  logic [$clog2(WINDOW)-1:0]      ld_idx,
   input  logic                           cmd_empty,
   output logic                           cmd_push,
   output rbr_pkg::cmd_type               cmd,
   output logic [$clog2(WINDOW)-1:0]      cmd_idx
);

   import rbr_pkg::*;

   localparam int IDX_W = $clog2(WINDOW);
   localparam int SUM_W = IDX_W + 1;
   localparam logic [SUM_W-1:0] WIN_SUM = SUM_W'(WINDOW);
   localparam logic [SEQ_W-1:0] WIN_SEQ = SEQ_W'(WINDOW);
   localparam logic [SEQ_W-1:0] TWO_SEQ = SEQ_W'(2);

   req_type          req_ff;
   logic             req_valid_ff, req_valid_in;
   logic             issue, accept;
   logic [SEQ_W-1:0] diff;
   logic [SUM_W-1:0] slot_sum, slot_wrap;

   // classify only once the back end has settled the previous request
   assign issue    = req_valid_ff && back_status.idle && cmd_empty;
   assign req_full = req_valid_ff && !issue;
   assign accept   = req_push && !req_full;
   assign cmd_push = issue;

   always_comb begin
      req_valid_in = req_valid_ff;
      if (accept) begin
         req_valid_in = 1'b1;
      end else if (issue) begin
         req_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_payload;
      end
   end

   // slot = (last_delivered mod WINDOW + d) mod WINDOW, meaningful for d <= WINDOW
   assign diff      = req_ff.seq_num - back_status.last_delivered;
   assign slot_sum  = SUM_W'(ld_idx) + diff[SUM_W-1:0];
   assign slot_wrap = (slot_sum >= WIN_SUM) ? slot_sum - WIN_SUM : slot_sum;
   assign cmd_idx   = slot_wrap[IDX_W-1:0];

   always_comb begin
      cmd.seq = req_ff.seq_num;
      cmd.msg = req_ff.message_word;
      priority if (req_ff.seq_num <= back_status.last_delivered) begin
         cmd.op = OP_DUP;
      end else if (diff > WIN_SEQ) begin
         cmd.op = OP_BEYOND;
      end else if (diff >= TWO_SEQ) begin
         cmd.op = OP_STORE;
      end else begin
         cmd.op = OP_NEXT;
      end
   end

endmodule

/* rtl/rbr_back.sv */
// Back end: slot store, in-order delivery and drain of stored messages.
module rbr_back #(
   parameter int WINDOW = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           cmd_empty,
   input  rbr_pkg::cmd_type               head_cmd,
   input  logic [$clog2(WINDOW)-1:0]      head_idx,
   output logic                           cmd_pop,
   input  logic                           rsp_full,
   output logic                           rsp_push,
   output rbr_pkg::rsp_type               rsp_data,
   output rbr_pkg::back_status_type       back_status,
   output logic [$clog2(WINDOW)-1:0]      ld_idx
);

   import rbr_pkg::*;

   localparam int IDX_W = $clog2(WINDOW);
   localparam int CNT_W = $clog2(WINDOW);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(WINDOW - 1);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_DELIV = 3'b010,
      ST_WALK  = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   logic [SEQ_W-1:0] ld_ff, ld_in;
   logic [IDX_W-1:0] ld_idx_ff, ld_idx_in;
   logic [WINDOW-1:0] valid_ff, valid_in;
   logic [SEQ_W-1:0] rx_seq_ff, rx_seq_in;
   logic [MSG_W-1:0] rx_msg_ff, rx_msg_in;
   logic [IDX_W-1:0] rx_idx_ff, rx_idx_in;
   logic [SEQ_W-1:0] walk_seq_ff, walk_seq_in;
   logic [IDX_W-1:0] walk_idx_ff, walk_idx_in;
   logic [CNT_W-1:0] walk_cnt_ff, walk_cnt_in;
   logic [MSG_W-1:0] rd_data_ff;
   logic [MSG_W-1:0] slot_mem [WINDOW];
   logic             mem_we;
   logic [IDX_W-1:0] walk_nidx;
   logic             dl_last, wk_last;

   function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
      return (i == LAST_IDX) ? '0 : i + 1'b1;
   endfunction

   assign back_status.idle           = (state_ff == ST_IDLE);
   assign back_status.last_delivered = ld_ff;
   assign ld_idx                     = ld_idx_ff;

   assign walk_nidx = idx_inc(walk_idx_ff);
   // the received message is walk 1; stored ones follow while slots are filled
   assign dl_last = (rx_seq_ff == SEQ_MAX) || !valid_ff[walk_idx_ff];
   assign wk_last = (walk_seq_ff == SEQ_MAX) || (walk_cnt_ff == LAST_CNT)
                    || !valid_ff[walk_nidx];

   always_comb begin
      state_in    = state_ff;
      ld_in       = ld_ff;
      ld_idx_in   = ld_idx_ff;
      valid_in    = valid_ff;
      rx_seq_in   = rx_seq_ff;
      rx_msg_in   = rx_msg_ff;
      rx_idx_in   = rx_idx_ff;
      walk_seq_in = walk_seq_ff;
      walk_idx_in = walk_idx_ff;
      walk_cnt_in = walk_cnt_ff;
      mem_we      = 1'b0;
      cmd_pop     = 1'b0;
      rsp_push    = 1'b0;
      rsp_data    = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty && !rsp_full) begin
               cmd_pop          = 1'b1;
               rsp_push         = 1'b1;
               rsp_data.kind    = KIND_STATUS;
               rsp_data.out_seq = head_cmd.seq;
               rsp_data.last    = 1'b1;
               unique case (head_cmd.op)
                  OP_DUP: begin
                     rsp_data.status = STATUS_DUP;
                  end
                  OP_BEYOND: begin
                     rsp_data.status = STATUS_BEYOND;
                  end
                  OP_STORE: begin
                     rsp_data.status = STATUS_STORED;
                     // a repeat keeps the first stored word
                     if (!valid_ff[head_idx]) begin
                        mem_we             = 1'b1;
                        valid_in[head_idx] = 1'b1;
                     end
                  end
                  OP_NEXT: begin
                     rsp_data.status = STATUS_DELIVERED;
                     rsp_data.last   = 1'b0;
                     rx_seq_in       = head_cmd.seq;
                     rx_msg_in       = head_cmd.msg;
                     rx_idx_in       = head_idx;
                     walk_seq_in     = head_cmd.seq + 1'b1;
                     walk_idx_in     = idx_inc(head_idx);
                     state_in        = ST_DELIV;
                  end
                  default: begin
                     rsp_data.status = STATUS_DUP;
                  end
               endcase
            end
         end
         ST_DELIV: begin
            if (!rsp_full) begin
               rsp_push             = 1'b1;
               rsp_data.kind        = KIND_DELIVER;
               rsp_data.status      = STATUS_DELIVERED;
               rsp_data.out_seq     = rx_seq_ff;
               rsp_data.out_message = rx_msg_ff;
               rsp_data.last        = dl_last;
               ld_in                = rx_seq_ff;
               ld_idx_in            = rx_idx_ff;
               walk_cnt_in          = CNT_W'(1);
               state_in             = dl_last ? ST_IDLE : ST_WALK;
            end
         end
         ST_WALK: begin
            if (!rsp_full) begin
               rsp_push              = 1'b1;
               rsp_data.kind         = KIND_DELIVER;
               rsp_data.status       = STATUS_DELIVERED;
               rsp_data.out_seq      = walk_seq_ff;
               rsp_data.out_message  = rd_data_ff;
               rsp_data.last         = wk_last;
               valid_in[walk_idx_ff] = 1'b0;
               ld_in                 = walk_seq_ff;
               ld_idx_in             = walk_idx_ff;
               if (wk_last) begin
                  state_in = ST_IDLE;
               end else begin
                  walk_seq_in = walk_seq_ff + 1'b1;
                  walk_idx_in = walk_nidx;
                  walk_cnt_in = walk_cnt_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ld_ff     <= '0;
         ld_idx_ff <= '0;
         valid_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         ld_ff     <= ld_in;
         ld_idx_ff <= ld_idx_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rx_seq_ff   <= rx_seq_in;
      rx_msg_ff   <= rx_msg_in;
      rx_idx_ff   <= rx_idx_in;
      walk_seq_ff <= walk_seq_in;
      walk_idx_ff <= walk_idx_in;
      walk_cnt_ff <= walk_cnt_in;
   end

   // read data always tracks the slot the walk will emit next
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[head_idx] <= head_cmd.msg;
      end
      rd_data_ff <= slot_mem[walk_idx_in];
   end

endmodule

/* rtl/reorder_buffer_receiver_core.sv */
// Top level of the selective-repeat receiver reorder buffer.
// The status result of a request passes the front-end request register, the command queue and
//   the result queue before it shows on rsp_ ports; a busy back end or a full result queue holds it.
// The front end waits for committed last_delivered and slot state before classifying the next
//   request, so the back end finishes all results of one request before it takes the next.
// Reset: synchronous; clears queues, last_delivered and all slot valid bits at once; slot
//   message storage is not cleared and no clearing pass runs.
module reorder_buffer_receiver_core #(
   parameter int WINDOW = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  rbr_pkg::req_type req_payload,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output rbr_pkg::rsp_type rsp_payload
);

   import rbr_pkg::*;

   localparam int IDX_W     = $clog2(WINDOW);
   localparam int CMD_W     = IDX_W + $bits(cmd_type);
   localparam int RSP_W     = $bits(rsp_type);
   localparam int CMD_DEPTH = 2;
   localparam int RSP_DEPTH = 2;

   // front to back: classified request plus its slot index
   cmd_type         cmd, head_cmd;
   logic [IDX_W-1:0] cmd_idx, head_idx;
   logic            cmd_push, cmd_pop, cmd_empty, cmd_full;
   logic [CMD_W-1:0] cmd_head;

   // back to front: committed state used for classification
   back_status_type back_status;
   logic [IDX_W-1:0] ld_idx;

   // back to result queue
   rsp_type         rsp_data;
   logic            rsp_push, rsp_full;
   logic [RSP_W-1:0] rsp_head;

   rbr_front #(
      .WINDOW (WINDOW)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_payload (req_payload),
      .back_status (back_status),
      .ld_idx      (ld_idx),
      .cmd_empty   (cmd_empty),
      .cmd_push    (cmd_push),
      .cmd         (cmd),
      .cmd_idx     (cmd_idx)
   );

   // command queue; front only pushes into an empty queue, so full never blocks
   rbr_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_q (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data ({cmd_idx, cmd}),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .empty     (cmd_empty),
      .pop_data  (cmd_head)
   );

   assign head_idx = cmd_head[CMD_W-1 -: IDX_W];
   assign head_cmd = cmd_type'(cmd_head[$bits(cmd_type)-1:0]);

   rbr_back #(
      .WINDOW (WINDOW)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_empty   (cmd_empty),
      .head_cmd    (head_cmd),
      .head_idx    (head_idx),
      .cmd_pop     (cmd_pop),
      .rsp_full    (rsp_full || cmd_full && 1'b0),
      .rsp_push    (rsp_push),
      .rsp_data    (rsp_data),
      .back_status (back_status),
      .ld_idx      (ld_idx)
   );

   // result queue parts the back end from the consumer
   rbr_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_data),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .pop_data  (rsp_head)
   );

   assign rsp_payload = rsp_type'(rsp_head);

endmodule

/* rtl/rbr_checker.sv */
// Port-level checks of the reorder buffer receiver, bound to the top level.
module rbr_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_full,
   input logic             rsp_empty,
   input logic             rsp_pop,
   input rbr_pkg::rsp_type rsp_payload
);

   import rbr_pkg::*;

   // a waiting result holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_payload))
      else $error("result changed while stalled");

   // status results carry no message word
   a_status_zero_msg: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_payload.kind == KIND_STATUS |-> rsp_payload.out_message == '0)
      else $error("status result with nonzero message");

   // every delivery is tagged delivered
   a_deliver_status: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_payload.kind == KIND_DELIVER
      |-> rsp_payload.status == STATUS_DELIVERED)
      else $error("delivery result with wrong status");

   // only an in-order request continues past its status result
   a_single_result_last: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_payload.kind == KIND_STATUS
      && rsp_payload.status != STATUS_DELIVERED |-> rsp_payload.last)
      else $error("single-result request without last");

   // nothing to deliver right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

endmodule

bind reorder_buffer_receiver_core rbr_checker u_rbr_checker (
   .clock       (clock),
   .reset       (reset),
   .req_full    (req_full),
   .rsp_empty   (rsp_empty),
   .rsp_pop     (rsp_pop),
   .rsp_payload (rsp_payload)
);

/* sim/rbr_order_check.sv */
// Request/result monitor and in-order delivery predictor for the reorder buffer receiver.
module rbr_order_check #(
   parameter int WINDOW = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  logic             req_full,
   input  rbr_pkg::req_type req_payload,
   input  logic             rsp_empty,
   input  logic             rsp_pop,
   input  rbr_pkg::rsp_type rsp_payload,
   output int               fail_count,
   output int               pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import rbr_pkg::*;

   localparam int PRINT_CAP = 40;

   // predicted receiver state
   logic [SEQ_W-1:0] delivered_upto;
   logic             slot_held [WINDOW];
   logic [MSG_W-1:0] slot_word [WINDOW];
   rsp_type          expected_q [$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   task automatic report_mismatch(input string msg);
      if (fail_count < PRINT_CAP) begin
         $display("[%0t] mismatch: %s", $time, msg);
      end
      fail_count++;
   endtask

   task automatic compare_field(input string name, input logic [SEQ_W-1:0] seq,
                                input logic [31:0] got, input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("seq 0x%0h %s got 0x%0h expected 0x%0h",
                                   seq, name, got, want));
      end
   endtask

   task automatic add_result(input logic kind, input logic [1:0] status,
                             input logic [SEQ_W-1:0] seq, input logic [MSG_W-1:0] msg);
      rsp_type r;
      r.kind        = kind;
      r.status      = status;
      r.out_seq     = seq;
      r.out_message = msg;
      r.last        = 1'b0;
      expected_q.push_back(r);
   endtask

   // status result first, then the in-order drain when the request is the next one
   task automatic predict_results(input req_type r);
      logic [SEQ_W-1:0] gap;
      logic [SEQ_W-1:0] nxt;
      int unsigned      idx;
      bit               walking;
      int               walked;
      rsp_type          tail;
      gap = r.seq_num - delivered_upto;
      if (r.seq_num <= delivered_upto) begin
         add_result(KIND_STATUS, STATUS_DUP, r.seq_num, '0);
      end else if (gap > WINDOW) begin
         add_result(KIND_STATUS, STATUS_BEYOND, r.seq_num, '0);
      end else if (gap >= 2) begin
         idx = r.seq_num % WINDOW;
         // a second copy of an early request keeps the first word
         if (!slot_held[idx]) begin
            slot_held[idx] = 1'b1;
            slot_word[idx] = r.message_word;
         end
         add_result(KIND_STATUS, STATUS_STORED, r.seq_num, '0);
      end else begin
         add_result(KIND_STATUS, STATUS_DELIVERED, r.seq_num, '0);
         add_result(KIND_DELIVER, STATUS_DELIVERED, r.seq_num, r.message_word);
         delivered_upto = r.seq_num;
         walked  = 1;
         walking = 1'b1;
         while (walking && walked < WINDOW) begin
            if (delivered_upto == SEQ_MAX) begin
               walking = 1'b0;
            end else begin
               nxt = delivered_upto + 1'b1;
               idx = nxt % WINDOW;
               if (!slot_held[idx]) begin
                  walking = 1'b0;
               end else begin
                  add_result(KIND_DELIVER, STATUS_DELIVERED, nxt, slot_word[idx]);
                  slot_held[idx] = 1'b0;
                  delivered_upto = nxt;
                  walked++;
               end
            end
         end
      end
      tail = expected_q.pop_back();
      tail.last = 1'b1;
      expected_q.push_back(tail);
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         delivered_upto = '0;
         for (int i = 0; i < WINDOW; i++) slot_held[i] = 1'b0;
         expected_q.delete();
      end else begin
         // results first, so a result never matches a prediction made at the same edge
         if (rsp_pop && !rsp_empty) begin
            if (expected_q.size() == 0) begin
               report_mismatch($sformatf("unexpected result seq 0x%0h",
                                         rsp_payload.out_seq));
            end else begin
               want = expected_q.pop_front();
               compare_field("kind", want.out_seq, rsp_payload.kind, want.kind);
               compare_field("status", want.out_seq, rsp_payload.status, want.status);
               compare_field("out_seq", want.out_seq, rsp_payload.out_seq, want.out_seq);
               compare_field("out_message", want.out_seq, rsp_payload.out_message,
                             want.out_message);
               compare_field("last", want.out_seq, rsp_payload.last, want.last);
            end
         end
         if (req_push && !req_full) predict_results(req_payload);
      end
      pending = expected_q.size();
   end

endmodule

/* sim/tb.sv */
// Testbench top for the reorder buffer receiver: stimulus, flow control and verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rbr_pkg::*;

   localparam int WINDOW       = 16;
   localparam int RANDOM_ITEMS = 400;
   // long receiver hold-off, starts once this many requests went in
   localparam int HOLD_AT      = 80;
   localparam int HOLD_CYCLES  = 400;
   // longest quiet stretch of a good run is the hold-off plus latency and
   // idling; the limit is several times that
   localparam int IDLE_LIMIT   = 4000;
   // quiet tail after every predicted result has come out
   localparam int DRAIN_CYCLES = 20;

   bit      clock;
   logic    reset;
   logic    req_push;
   logic    req_full;
   req_type req_payload;
   logic    rsp_empty;
   logic    rsp_pop;
   rsp_type rsp_payload;

   int fail_count;
   int pending;

   // written by the stimulus process only
   int items_sent;
   int send_idle_pct;
   int recv_idle_pct;
   // written by the result side only
   bit hold_done;

   reorder_buffer_receiver_core #(
      .WINDOW(WINDOW)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_payload(req_payload),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_payload(rsp_payload)
   );

   rbr_order_check #(
      .WINDOW(WINDOW)
   ) order_check (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_payload(req_payload),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_payload(rsp_payload),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // One request: random idle cycles first, then hold push until accepted.
   // Entered and left at a falling edge; push stays high on return so a
   // back-to-back request does not drop it.
   task automatic send_item(input logic [SEQ_W-1:0] seq, input logic [MSG_W-1:0] msg);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push = 1'b0;
         @(negedge clock);
      end
      req_push                 = 1'b1;
      req_payload.seq_num      = seq;
      req_payload.message_word = msg;
      do @(posedge clock); while (req_full);
      items_sent++;
      @(negedge clock);
   endtask

   initial begin : stimulus
      logic [SEQ_W-1:0] base;
      logic [SEQ_W-1:0] order [WINDOW];
      logic [SEQ_W-1:0] tmp;
      int               k;
      int               j;
      int               s;
      int               rand_sent;
      reset         = 1'b1;
      req_push      = 1'b0;
      req_payload   = '0;
      items_sent    = 0;
      send_idle_pct = 28;
      recv_idle_pct = 63;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // ---- directed part, starting from last delivered = 0 ----
      send_item('0, '0);                  // zero is already delivered: duplicate
      send_item(SEQ_MAX, '1);             // far top of the sequence space: beyond
      send_item(32'd17, 32'h5555_5555);   // one past the window edge: beyond
      send_item(32'd16, '1);              // right at the window edge: stored
      send_item(32'd2, 32'hAAAA_AAAA);    // early: stored
      send_item(32'd2, 32'h1234_5678);    // stored again, first word must win
      send_item(32'd1, 32'h0);            // next: delivers 1 then stored 2
      send_item(32'd2, $urandom);         // equal to last delivered: duplicate
      // fill the whole window above 3, then send 3: the longest drain
      for (s = 18; s >= 4; s--) send_item(s, $urandom);
      send_item(32'd3, $urandom);
      base = 32'd18;

      // ---- random part: shuffled in-window blocks plus noise ----
      rand_sent = 0;
      while (rand_sent < RANDOM_ITEMS) begin
         // idle mix per third: sender light / receiver heavy, swapped, none
         case (rand_sent * 3 / RANDOM_ITEMS)
            0: begin
               send_idle_pct = 28;
               recv_idle_pct = 63;
            end
            1: begin
               send_idle_pct = 63;
               recv_idle_pct = 28;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase

         // block size: mostly short, often a full window for long drains
         j = $urandom_range(9);
         if (j == 0) k = 1;
         else if (j < 3) k = WINDOW;
         else k = $urandom_range(8, 2);

         for (int i = 0; i < k; i++) order[i] = base + 1 + i;
         for (int i = k - 1; i > 0; i--) begin
            j        = $urandom_range(i, 0);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
         end

         for (int i = 0; i < k; i++) begin
            if ($urandom_range(99) < 20) begin
               case ($urandom_range(4))
                  0: send_item(base - $urandom_range(20), $urandom);      // old: duplicate, or beyond if it wraps
                  1: send_item(order[$urandom_range(i, 0)], $urandom);   // repeat in block
                  2: send_item(base + 17 + $urandom_range(300), $urandom); // past window
                  3: send_item($urandom, $urandom);                       // wild
                  default: send_item(($urandom_range(1)) ? SEQ_MAX : '0, $urandom);
               endcase
               rand_sent++;
            end
            send_item(order[i], $urandom);
            rand_sent++;
         end
         base = base + k;
      end
      req_push = 1'b0;

      // everything predicted must come out, then a quiet tail
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0) $display("tb passed");
      else $display("tb failed");
      $finish;
   end

   // Result side: random pops, plus one long hold-off so the queue backs up
   // into the request side while requests keep coming.
   initial begin : drain_side
      rsp_pop   = 1'b0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && items_sent >= HOLD_AT) begin
            hold_done = 1'b1;
            rsp_pop   = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_pop = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: too many cycles without a request or result moving.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) quiet = 0;
         else quiet++;
      end
      $display("tb failed");
      $finish;
   end

endmodule

/* filelist.f */
rtl/rbr_pkg.sv
rtl/rbr_fifo.sv
rtl/rbr_front.sv
rtl/rbr_back.sv
rtl/reorder_buffer_receiver_core.sv
rtl/rbr_checker.sv
sim/rbr_order_check.sv
sim/tb.sv
